>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RPSQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");
`define RPSQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define RPSQ_ASSERT(lbl, clk, rstn, prop)
`define RPSQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> src/rpsq_pkg.sv
// ----------------------------------------------------------------------------
// Random-pick slot queue package
// Field widths, reset values and status codes of the slot queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpsq_pkg;

  localparam int unsigned SlotsDefault = 16;

  localparam int unsigned CapW = 5;
  localparam int unsigned ValW = 32;
  localparam int unsigned RndW = 16;
  localparam int unsigned StatW = 2;

  // Highest capacity the register can express; no slot above it is ever used.
  localparam int unsigned MaxSlots = (2 ** CapW) - 1;

  localparam logic [CapW-1:0] CapReset = CapW'(12);

  localparam logic [StatW-1:0] StatusOk = 2'd0;
  localparam logic [StatW-1:0] StatusFull = 2'd1;
  localparam logic [StatW-1:0] StatusEmpty = 2'd2;

  localparam logic [ValW-1:0] EmptyValue = '1;

endpackage

`default_nettype wire

>>> src/random_pick_slot_queue_top.sv
// ----------------------------------------------------------------------------
// Random-pick slot queue
// Slot store with put to the lowest free slot and get from a random slot.
// ----------------------------------------------------------------------------
// Every transaction produces one result. A put when the count has already reached
// the capacity skips the search; otherwise the free-slot search visits k slots
// (1 to capacity), counting upward from slot 0. A get on an empty store skips
// the search; any other get first forms the bit-serial remainder of the random
// value by the capacity, then runs the one-slot-per-cycle search for a used
// slot, visiting k slots (1 up to the slot count), and then does the registered
// read of the value memory. The next transaction is taken as soon as the result
// has moved into the output register.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module random_pick_slot_queue_top #(
  parameter int unsigned SLOTS = rpsq_pkg::SlotsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i,     // capacity

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,    // put_value[31:0], random_value[47:32]
  input  wire logic        s_axis_tuser,    // opcode

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,    // got_value[31:0], count_after[36:32],
                                            // is_empty[37], is_full[38], zero[39]
  output logic [1:0]       m_axis_tuser     // status
);

  localparam int unsigned CapW = rpsq_pkg::CapW;
  localparam int unsigned ValW = rpsq_pkg::ValW;
  localparam int unsigned RndW = rpsq_pkg::RndW;
  localparam int unsigned StatW = rpsq_pkg::StatW;
  localparam int unsigned NumSlots =
    (SLOTS < rpsq_pkg::MaxSlots) ? SLOTS : rpsq_pkg::MaxSlots;
  localparam int unsigned IdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int unsigned BitW = $clog2(RndW);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StScan = 3'd2;
  localparam logic [2:0] StRead = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  localparam logic OpPut = 1'b0;
  localparam logic OpGet = 1'b1;

  logic [2:0]             state_q, state_d;
  logic [CapW-1:0]        cap_q;
  logic [CapW-1:0]        cap_eff;
  logic                   op_q, op_d;
  logic signed [ValW-1:0] val_q, val_d;
  logic [RndW-1:0]        rnd_q, rnd_d;
  logic [CapW-1:0]        rem_q, rem_d;
  logic [CapW:0]          trial;
  logic [BitW-1:0]        bit_q, bit_d;
  logic [IdxW-1:0]        pos_q, pos_d;
  logic [CapW-1:0]        pos_inc;
  logic [NumSlots-1:0]    used_q, used_d;
  logic [CapW-1:0]        count_q, count_d;
  logic signed [ValW-1:0] res_got_q, res_got_d;
  logic [StatW-1:0]       res_stat_q, res_stat_d;
  logic                   mem_we;
  logic signed [ValW-1:0] mem_q [NumSlots];
  logic signed [ValW-1:0] rdata_q;

  logic                   out_valid_q, out_valid_d;
  logic signed [ValW-1:0] out_got_q, out_got_d;
  logic [StatW-1:0]       out_stat_q, out_stat_d;
  logic [CapW-1:0]        out_count_q, out_count_d;
  logic                   out_empty_q, out_empty_d;
  logic                   out_full_q, out_full_d;

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CapW'(1);
    end else if (cap_q > CapW'(NumSlots)) begin
      cap_eff = CapW'(NumSlots);
    end else begin
      cap_eff = cap_q;
    end
  end

  assign trial = {rem_q, rnd_q[RndW-1]};
  assign pos_inc = CapW'(pos_q) + CapW'(1);

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    val_d = val_q;
    rnd_d = rnd_q;
    rem_d = rem_q;
    bit_d = bit_q;
    pos_d = pos_q;
    used_d = used_q;
    count_d = count_q;
    res_got_d = res_got_q;
    res_stat_d = res_stat_q;
    mem_we = 1'b0;
    out_valid_d = out_valid_q;
    out_got_d = out_got_q;
    out_stat_d = out_stat_q;
    out_count_d = out_count_q;
    out_empty_d = out_empty_q;
    out_full_d = out_full_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          op_d = s_axis_tuser;
          val_d = s_axis_tdata[31:0];
          rnd_d = s_axis_tdata[47:32];
          rem_d = '0;
          bit_d = BitW'(RndW - 1);
          pos_d = '0;
          res_got_d = '0;
          res_stat_d = rpsq_pkg::StatusOk;
          if (s_axis_tuser == OpPut) begin
            if (count_q >= cap_eff) begin
              res_stat_d = rpsq_pkg::StatusFull;
              state_d = StDone;
            end else begin
              state_d = StScan;
            end
          end else begin
            if (count_q == '0) begin
              res_got_d = rpsq_pkg::EmptyValue;
              res_stat_d = rpsq_pkg::StatusEmpty;
              state_d = StDone;
            end else begin
              state_d = StDiv;
            end
          end
        end
      end
      StDiv: begin
        if (trial >= {1'b0, cap_eff}) begin
          rem_d = CapW'(trial - {1'b0, cap_eff});
        end else begin
          rem_d = trial[CapW-1:0];
        end
        rnd_d = rnd_q << 1;
        bit_d = bit_q - BitW'(1);
        if (bit_q == '0) begin
          pos_d = rem_d[IdxW-1:0];
          state_d = StScan;
        end
      end
      StScan: begin
        if (op_q == OpPut) begin
          if (!used_q[pos_q]) begin
            mem_we = 1'b1;
            used_d[pos_q] = 1'b1;
            count_d = count_q + CapW'(1);
            state_d = StDone;
          end else if (pos_inc == cap_eff) begin
            res_stat_d = rpsq_pkg::StatusFull;
            state_d = StDone;
          end else begin
            pos_d = pos_q + IdxW'(1);
          end
        end else begin
          if (used_q[pos_q]) begin
            used_d[pos_q] = 1'b0;
            count_d = count_q - CapW'(1);
            state_d = StRead;
          end else if (pos_q == IdxW'(NumSlots - 1)) begin
            pos_d = '0;
          end else begin
            pos_d = pos_q + IdxW'(1);
          end
        end
      end
      StRead: begin
        res_got_d = rdata_q;
        state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_got_d = res_got_q;
          out_stat_d = res_stat_q;
          out_count_d = count_q;
          out_empty_d = (count_q == '0);
          out_full_d = (count_q >= cap_eff);
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cap_q <= rpsq_pkg::CapReset;
      used_q <= '0;
      count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      used_q <= used_d;
      count_q <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    val_q <= val_d;
    rnd_q <= rnd_d;
    rem_q <= rem_d;
    bit_q <= bit_d;
    pos_q <= pos_d;
    res_got_q <= res_got_d;
    res_stat_q <= res_stat_d;
    out_got_q <= out_got_d;
    out_stat_q <= out_stat_d;
    out_count_q <= out_count_d;
    out_empty_q <= out_empty_d;
    out_full_q <= out_full_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[pos_q] <= val_q;
    end
    rdata_q <= mem_q[pos_q];
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {1'b0, out_full_q, out_empty_q, out_count_q, out_got_q};
  assign m_axis_tuser = out_stat_q;

  `RPSQ_ASSERT(a_count_matches_used, clk_i, rst_ni, $countones(used_q) == int'(count_q))
  `RPSQ_ASSERT(a_get_scan_not_empty, clk_i, rst_ni, (state_q == StScan && op_q == OpGet) |-> count_q != '0)
  `RPSQ_ASSERT(a_empty_returns_minus_one, clk_i, rst_ni, (out_valid_q && out_stat_q == rpsq_pkg::StatusEmpty) |-> out_got_q == rpsq_pkg::EmptyValue)
  `RPSQ_ASSERT(a_count_bounded, clk_i, rst_ni, count_q <= CapW'(NumSlots))
  `RPSQ_ASSERT_ALWAYS(a_reset_clears_valid, clk_i, !rst_ni |=> !out_valid_q)

endmodule

`default_nettype wire
